// ----- hw/rtl/dsam_pkg.sv -----
// dsam_pkg: shared types, codes and helpers for the decimal add/multiply block.
// Used by the interfaces, the operand store, the engine and the top level.
package dsam_pkg;

  localparam int DIGIT_W = 4;
  localparam int ERR_W = 2;
  localparam int MAX_OUT = 32;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_DIGIT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;
  localparam logic [ERR_W-1:0] ERR_MIXED_ADD = 2'd3;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // operation request handed from the load side to the engine
  typedef struct packed {
    logic             go;
    logic             cmd;
    logic [ERR_W-1:0] err;
    logic             lsign;
    logic             rsign;
  } start_t;

  typedef struct packed {
    logic [3:0] quo;
    logic [3:0] rem;
  } divmod_t;

  // s <= 99: quotient by reciprocal multiply, remainder by subtract
  function automatic divmod_t div10(input logic [6:0] s);
    logic [13:0] prod;
    logic [3:0]  q;
    logic [6:0]  qx10;
    divmod_t     r;
    prod = 14'(s) * 14'd103;
    q = prod[13:10];
    qx10 = 7'(q) * 7'd10;
    r.quo = q;
    r.rem = 4'(s - qx10);
    return r;
  endfunction

endpackage

// ----- hw/rtl/dsam_if.sv -----
// dsam_if: valid/ready channels for operand digit words and result words.
// Depends on dsam_pkg for field widths.
interface dsam_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         which_operand;
  logic [dsam_pkg::DIGIT_W-1:0] digit_value;
  logic                         operand_negative;
  logic                         last_digit;

  modport source (output valid, cmd, which_operand, digit_value, operand_negative,
                  last_digit, input ready);
  modport sink (input valid, cmd, which_operand, digit_value, operand_negative,
                last_digit, output ready);
endinterface

interface dsam_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsam_pkg::DIGIT_W-1:0] result_digit;
  logic                         result_negative;
  logic                         result_last;
  logic [dsam_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, result_digit, result_negative, result_last, error_code,
                  input ready);
  modport sink (input valid, result_digit, result_negative, result_last, error_code,
                output ready);
endinterface

// ----- hw/rtl/decimal_string_add_multiply_top.sv -----
// decimal_string_add_multiply_top: signed decimal add / multiply, digit serial.
// Depends on dsam_pkg, dsam_if, dsam_store, dsam_engine.
//
// Usage:
//   operand channel: one word per decimal digit, most significant first.
//     which_operand picks left (0) or right (1); operand_negative counts while
//     the operand has no significant digit yet; leading zeros are dropped.
//     The right operand's word with last_digit set starts the operation
//     named by cmd (0 add, 1 multiply).
//   result channel: decimal digits most significant first, last one marked,
//     or a single word with error_code set (bad digit, too long, mixed add).
// Operation:
//   ready drops while an operation runs.
//   Add: digit positions 0 to MAX_DIGITS, then trim and output.
//   Multiply: one digit pair per cycle within each row, through one
//     4x4 multiplier and the accumulator memory port, then trim.
//   Trim: a read and a check per leading zero; output: a read and a write per digit.
// Reset clears counts, signs, latched error and the sequencer; digit
// memories are not cleared. A stalled receiver holds the current result
// word; the engine waits, and after the final word the operand side is
// open again even while that word is still pending.
module decimal_string_add_multiply_top #(
  parameter int MAX_DIGITS = 16
) (
  input logic         clk,
  input logic         rst,
  dsam_in_if.sink     operand,
  dsam_out_if.source  result
);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic accept, trigger, busy, start_q, cmd_q;
  logic [dsam_pkg::ERR_W-1:0] load_error;
  logic lwr, rwr, ltoo, rtoo, lsign, rsign;
  logic [CW-1:0] lcount, rcount;
  logic [AW-1:0] laddr, raddr;
  logic [dsam_pkg::DIGIT_W-1:0] ldata, rdata;
  dsam_pkg::start_t start;

  // loads are refused while an operation is being set up or run
  assign operand.ready = !busy && !start_q;
  assign accept = operand.valid && operand.ready;
  assign trigger = accept && operand.which_operand && operand.last_digit;
  assign lwr = accept && !operand.which_operand;
  assign rwr = accept && operand.which_operand;

  dsam_store #(.MAX_DIGITS(MAX_DIGITS)) u_left (
    .clk(clk), .rst(rst), .wr(lwr), .digit(operand.digit_value),
    .neg(operand.operand_negative), .clr(start_q), .raddr(laddr), .rdata(ldata),
    .count(lcount), .sign(lsign), .too_long(ltoo)
  );

  dsam_store #(.MAX_DIGITS(MAX_DIGITS)) u_right (
    .clk(clk), .rst(rst), .wr(rwr), .digit(operand.digit_value),
    .neg(operand.operand_negative), .clr(start_q), .raddr(raddr), .rdata(rdata),
    .count(rcount), .sign(rsign), .too_long(rtoo)
  );

  // first load error wins; cleared when the operation takes its snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      load_error <= dsam_pkg::ERR_NONE;
      start_q <= 1'b0;
    end else begin
      start_q <= trigger;
      if (trigger) cmd_q <= operand.cmd;
      if (start_q) begin
        load_error <= dsam_pkg::ERR_NONE;
      end else if (accept && load_error == dsam_pkg::ERR_NONE) begin
        if (operand.digit_value > dsam_pkg::DIGIT_MAX) load_error <= dsam_pkg::ERR_BAD_DIGIT;
        else if (ltoo || rtoo) load_error <= dsam_pkg::ERR_TOO_LONG;
      end
    end
  end

  // an all-zero or empty operand counts as plus
  assign start.go = start_q;
  assign start.cmd = cmd_q;
  assign start.err = load_error;
  assign start.lsign = lsign && (lcount != '0);
  assign start.rsign = rsign && (rcount != '0);

  dsam_engine #(.MAX_DIGITS(MAX_DIGITS)) u_engine (
    .clk(clk), .rst(rst), .start(start), .lcount(lcount), .rcount(rcount),
    .laddr(laddr), .raddr(raddr), .ldata(ldata), .rdata(rdata), .busy(busy),
    .result(result)
  );
endmodule

// ----- hw/rtl/dsam_store.sv -----
// dsam_store: one operand's digit memory, significant digit count and sign.
// Depends on dsam_pkg.
module dsam_store #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr,
  input  logic [dsam_pkg::DIGIT_W-1:0]          digit,
  input  logic                                  neg,
  input  logic                                  clr,
  input  logic [$clog2(MAX_DIGITS)-1:0]         raddr,
  output logic [dsam_pkg::DIGIT_W-1:0]          rdata,
  output logic [$clog2(MAX_DIGITS+1)-1:0]       count,
  output logic                                  sign,
  output logic                                  too_long
);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [dsam_pkg::DIGIT_W-1:0] mem [MAX_DIGITS];
  logic significant;
  logic full;

  assign significant = (digit <= dsam_pkg::DIGIT_MAX) &&
                       !((count == '0) && (digit == '0));
  assign full = (count >= CW'(MAX_DIGITS));
  assign too_long = wr && significant && full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sign <= 1'b0;
    end else if (clr) begin
      count <= '0;
      sign <= 1'b0;
    end else if (wr) begin
      if (count == '0) sign <= sign | neg;
      if (significant && !full) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !clr && significant && !full) mem[count[AW-1:0]] <= digit;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/dsam_engine.sv -----
// dsam_engine: digit-serial add / long multiply into a digit accumulator,
// leading zero trim and result word output. Depends on dsam_pkg, dsam_if.
module dsam_engine #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dsam_pkg::start_t                  start,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]   lcount,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]   rcount,
  output logic [$clog2(MAX_DIGITS)-1:0]     laddr,
  output logic [$clog2(MAX_DIGITS)-1:0]     raddr,
  input  logic [dsam_pkg::DIGIT_W-1:0]      ldata,
  input  logic [dsam_pkg::DIGIT_W-1:0]      rdata,
  output logic                              busy,
  dsam_out_if.source                        result
);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int ACC_LEN = 2 * MAX_DIGITS + 1;
  localparam int PW = $clog2(ACC_LEN);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR = 4'd1;
  localparam logic [3:0] S_ADD = 4'd2;
  localparam logic [3:0] S_MUL = 4'd3;
  localparam logic [3:0] S_GAP = 4'd4;
  localparam logic [3:0] S_ZERO = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_TRIM_RD = 4'd7;
  localparam logic [3:0] S_TRIM_CK = 4'd8;
  localparam logic [3:0] S_EMIT_RD = 4'd9;
  localparam logic [3:0] S_EMIT_WR = 4'd10;

  localparam logic [1:0] K_ADD = 2'd0;
  localparam logic [1:0] K_MAC = 2'd1;
  localparam logic [1:0] K_CARRY = 2'd2;

  logic [3:0] state;
  logic [PW-1:0] lc, rc, i, t;
  logic [CW-1:0] j;
  logic neg;
  logic [dsam_pkg::ERR_W-1:0] err;
  logic [dsam_pkg::DIGIT_W-1:0] carry;

  // pipeline stage between operand reads and accumulator write
  logic p_v, p_first, p_lv, p_rv;
  logic [1:0] p_kind;
  logic [PW-1:0] p_pos;

  logic [dsam_pkg::DIGIT_W-1:0] acc [ACC_LEN];
  logic [dsam_pkg::DIGIT_W-1:0] acc_rdata;
  logic [PW-1:0] acc_raddr, acc_waddr;
  logic [dsam_pkg::DIGIT_W-1:0] acc_wdata;
  logic acc_we;

  logic [6:0] sum;
  dsam_pkg::divmod_t dm;
  logic free;
  logic out_valid;

  assign busy = (state != S_IDLE);
  assign free = !out_valid || result.ready;
  assign result.valid = out_valid;

  // operand and accumulator addresses for the current issue
  always_comb begin
    laddr = AW'(lc - 1'b1 - i);
    raddr = (state == S_MUL) ? AW'(rc - 1'b1 - PW'(j)) : AW'(rc - 1'b1 - i);
    unique case (state)
      S_MUL: acc_raddr = i + PW'(j);
      S_TRIM_RD, S_TRIM_CK: acc_raddr = t;
      default: acc_raddr = t;
    endcase
  end

  always_comb begin
    unique case (p_kind)
      K_MAC: sum = 7'(p_first ? 4'd0 : acc_rdata) + 7'(ldata) * 7'(rdata) + 7'(carry);
      K_ADD: sum = 7'(p_lv ? ldata : 4'd0) + 7'(p_rv ? rdata : 4'd0) + 7'(carry);
      default: sum = 7'(carry);
    endcase
    dm = dsam_pkg::div10(sum);
    acc_we = p_v || (state == S_ZERO);
    acc_waddr = p_v ? p_pos : '0;
    acc_wdata = p_v ? dm.rem : '0;
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc[acc_waddr] <= acc_wdata;
    acc_rdata <= acc[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (result.ready) out_valid <= 1'b0;
      p_v <= 1'b0;
      if (p_v) carry <= (p_kind == K_CARRY) ? 4'd0 : dm.quo;
      unique case (state)
        S_IDLE: begin
          if (start.go) begin
            lc <= PW'(lcount);
            rc <= PW'(rcount);
            i <= '0;
            j <= '0;
            carry <= '0;
            if (start.err != dsam_pkg::ERR_NONE) begin
              err <= start.err;
              state <= S_ERR;
            end else if (start.cmd == dsam_pkg::CMD_ADD) begin
              if (start.lsign != start.rsign) begin
                err <= dsam_pkg::ERR_MIXED_ADD;
                state <= S_ERR;
              end else begin
                neg <= start.lsign;
                state <= S_ADD;
              end
            end else begin
              neg <= start.lsign ^ start.rsign;
              state <= (lcount == '0 || rcount == '0) ? S_ZERO : S_MUL;
            end
          end
        end
        S_ERR: begin
          if (free) begin
            out_valid <= 1'b1;
            result.result_digit <= '0;
            result.result_negative <= 1'b0;
            result.result_last <= 1'b1;
            result.error_code <= err;
            state <= S_IDLE;
          end
        end
        S_ADD: begin
          p_v <= 1'b1;
          p_kind <= K_ADD;
          p_pos <= i;
          p_lv <= (i < lc);
          p_rv <= (i < rc);
          i <= i + 1'b1;
          if (i == PW'(MAX_DIGITS)) begin
            t <= PW'(MAX_DIGITS);
            state <= S_WAIT;
          end
        end
        S_MUL: begin
          p_v <= 1'b1;
          p_first <= (i == '0);
          if (PW'(j) < rc) begin
            p_kind <= K_MAC;
            p_pos <= i + PW'(j);
            j <= j + 1'b1;
          end else begin
            p_kind <= K_CARRY;
            p_pos <= i + rc;
            j <= '0;
            i <= i + 1'b1;
            state <= S_GAP;
          end
        end
        S_GAP: begin
          if (i == lc) begin
            t <= lc + rc - 1'b1;
            state <= S_WAIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_ZERO: begin
          t <= '0;
          state <= S_TRIM_RD;
        end
        S_WAIT: state <= S_TRIM_RD;
        S_TRIM_RD: state <= S_TRIM_CK;
        S_TRIM_CK: begin
          if (acc_rdata == '0 && t != '0) begin
            t <= t - 1'b1;
            state <= S_TRIM_RD;
          end else begin
            if (t == '0 && acc_rdata == '0) neg <= 1'b0;
            if (32'(t) > dsam_pkg::MAX_OUT - 1) t <= PW'(dsam_pkg::MAX_OUT - 1);
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state <= S_EMIT_WR;
        S_EMIT_WR: begin
          if (free) begin
            out_valid <= 1'b1;
            result.result_digit <= acc_rdata;
            result.result_negative <= neg;
            result.result_last <= (t == '0);
            result.error_code <= dsam_pkg::ERR_NONE;
            if (t == '0) begin
              state <= S_IDLE;
            end else begin
              t <= t - 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
